### rtl/core/ccb_pkg.sv
// Shared types, constants and helpers for the color-key sprite blitter.
`timescale 1ns / 1ps

package ccb_pkg;

   localparam int DIM_W   = 10;
   localparam int POS_W   = 11;
   localparam int PIX_W   = 8;
   localparam int ADDR_W  = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int CCB_MAX_DIM = 1024;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR     = 2'd2;

   localparam logic [DIM_W-1:0] SCREEN_WIDTH_RESET  = 10'd220;
   localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RESET = 10'd176;
   localparam logic [PIX_W-1:0] TRANSPARENT_RESET   = 8'd0;

   typedef struct packed {
      logic [DIM_W-1:0] sx;
      logic [DIM_W-1:0] sy;
      logic [PIX_W-1:0] pixel;
   } ccb_job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } ccb_queue_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int max_dim);
      logic [DIM_W-1:0] r;
      r = v;
      if (32'(v) > 32'(max_dim - 1)) begin
         r = DIM_W'(max_dim - 1);
      end
      return r;
   endfunction

endpackage

### rtl/core/ccb_front.sv
// Front end: accepts items, walks the bitmap, clips and queues writes.
`timescale 1ns / 1ps

module ccb_front #(
   parameter int MAX_DIM = ccb_pkg::CCB_MAX_DIM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic signed [ccb_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [ccb_pkg::POS_W-1:0]  req_pos_y,
   input  logic [ccb_pkg::DIM_W-1:0]         req_bmp_width,
   input  logic [ccb_pkg::DIM_W-1:0]         req_bmp_height,
   input  logic [ccb_pkg::DIM_W-1:0]         req_clip_width,
   input  logic [ccb_pkg::DIM_W-1:0]         req_clip_height,
   input  logic [ccb_pkg::PIX_W-1:0]         req_pixel,
   input  logic [ccb_pkg::DIM_W-1:0]         screen_width,
   input  logic [ccb_pkg::DIM_W-1:0]         screen_height,
   input  logic [ccb_pkg::PIX_W-1:0]         key_color,
   input  ccb_pkg::ccb_queue_status_type     queue_status,
   output logic                              push,
   output ccb_pkg::ccb_job_type              job
);
   import ccb_pkg::*;

   logic signed [POS_W-1:0] origin_x_ff, origin_x_in;
   logic signed [POS_W-1:0] origin_y_ff, origin_y_in;
   logic [DIM_W-1:0] span_w_ff, span_w_in;
   logic [DIM_W-1:0] span_h_ff, span_h_in;
   logic [DIM_W-1:0] window_w_ff, window_w_in;
   logic [DIM_W-1:0] window_h_ff, window_h_in;
   logic [DIM_W-1:0] column_ff, column_in;
   logic [DIM_W-1:0] row_ff, row_in;

   logic             accept;
   logic             walk;
   logic [DIM_W:0]   column_next;
   logic signed [POS_W:0] sx;
   logic signed [POS_W:0] sy;
   logic [POS_W-1:0] clip_x;
   logic [POS_W-1:0] clip_y;
   logic             on_screen;
   logic             in_clip;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign walk      = accept && (req_func == FUNC_PIXEL) && (span_w_ff != '0)
                      && (row_ff < span_h_ff);

   assign sx = {origin_x_ff[POS_W-1], origin_x_ff} + $signed({2'b00, column_ff});
   assign sy = {origin_y_ff[POS_W-1], origin_y_ff} + $signed({2'b00, row_ff});

   assign clip_x = origin_x_ff[POS_W-1] ? sx[POS_W-1:0] : {1'b0, column_ff};
   assign clip_y = origin_y_ff[POS_W-1] ? sy[POS_W-1:0] : {1'b0, row_ff};

   assign on_screen = !sx[POS_W] && !sy[POS_W]
                      && (sx[POS_W-1:0] < {1'b0, screen_width})
                      && (sy[POS_W-1:0] < {1'b0, screen_height});
   assign in_clip   = (clip_x < {1'b0, window_w_ff}) && (clip_y < {1'b0, window_h_ff});

   assign push      = walk && on_screen && in_clip && (req_pixel != key_color);
   assign job.sx    = sx[DIM_W-1:0];
   assign job.sy    = sy[DIM_W-1:0];
   assign job.pixel = req_pixel;

   assign column_next = {1'b0, column_ff} + 1'b1;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      span_w_in   = span_w_ff;
      span_h_in   = span_h_ff;
      window_w_in = window_w_ff;
      window_h_in = window_h_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      if (accept && (req_func == FUNC_START)) begin
         origin_x_in = req_pos_x;
         origin_y_in = req_pos_y;
         span_w_in   = clamp_dim(req_bmp_width, MAX_DIM);
         span_h_in   = clamp_dim(req_bmp_height, MAX_DIM);
         window_w_in = clamp_dim(req_clip_width, MAX_DIM);
         window_h_in = clamp_dim(req_clip_height, MAX_DIM);
         column_in   = '0;
         row_in      = '0;
      end else if (walk) begin
         if (column_next >= {1'b0, span_w_ff}) begin
            column_in = '0;
            row_in    = row_ff + 1'b1;
         end else begin
            column_in = column_next[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         span_w_ff   <= '0;
         span_h_ff   <= '0;
         window_w_ff <= '0;
         window_h_ff <= '0;
         column_ff   <= '0;
         row_ff      <= '0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         span_w_ff   <= span_w_in;
         span_h_ff   <= span_h_in;
         window_w_ff <= window_w_in;
         window_h_ff <= window_h_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
      end
   end

endmodule

### rtl/core/ccb_queue.sv
// Two-entry queue of pending frame-buffer writes between front and back.
`timescale 1ns / 1ps

module ccb_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ccb_pkg::ccb_job_type          push_job,
   input  logic                          pop,
   output ccb_pkg::ccb_job_type          head_job,
   output ccb_pkg::ccb_queue_status_type status
);
   import ccb_pkg::*;

   ccb_job_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head_job         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("write transfer into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> status.not_empty)
      else $error("read from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a write");

endmodule

### rtl/core/ccb_back.sv
// Back end: forms the frame-buffer address and holds the result register.
`timescale 1ns / 1ps

module ccb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ccb_pkg::ccb_job_type          head_job,
   input  ccb_pkg::ccb_queue_status_type queue_status,
   output logic                          pop,
   input  logic [ccb_pkg::DIM_W-1:0]     screen_width,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ccb_pkg::ADDR_W-1:0]    rsp_write_address,
   output logic [ccb_pkg::PIX_W-1:0]     rsp_write_pixel
);
   import ccb_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] address_ff, address_in;
   logic [PIX_W-1:0]  pixel_ff;
   logic [2*DIM_W-1:0] row_base;
   logic [ADDR_W-1:0] sum;
   logic              load;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign pop  = load && queue_status.not_empty;

   assign row_base   = (2*DIM_W)'(head_job.sy) * (2*DIM_W)'(screen_width);
   assign sum        = ADDR_W'(row_base) + ADDR_W'(head_job.sx);
   assign address_in = sum;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = queue_status.not_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         address_ff <= address_in;
         pixel_ff   <= head_job.pixel;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = address_ff;
   assign rsp_write_pixel   = pixel_ff;

endmodule

### rtl/core/clipped_color_key_blitter.sv
// Top level of the color-key sprite blitter with clipping.
//
// Request channel (req_*): a start item (func 0) loads position, bitmap size
// and clip size and rewinds the pixel walk; each pixel item (func 1) carries
// the next source pixel in row-major order. Response channel (rsp_*): one
// frame-buffer write per visible, in-window, non-transparent pixel.
// Both channels transfer on valid high and stall low.
// A written pixel is held in a queue entry, then in the back's result register.
// Throughput, unless stalled: one item per cycle; the front classifies a
// pixel in the cycle it arrives, the back's single multiply-add forms one
// address per cycle. A two-entry queue separates them; req_stall rises only
// when it is full, which happens while the receiver holds rsp_stall.
// The csr_* port writes screen width, height and transparent color; write
// it only while idle.
// Reset clears the walk state and the queue and restores the registers to
// 220, 176 and 0; no response is pending after reset.
`timescale 1ns / 1ps

module clipped_color_key_blitter #(
   parameter int MAX_DIM = ccb_pkg::CCB_MAX_DIM
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic signed [ccb_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [ccb_pkg::POS_W-1:0]    req_pos_y,
   input  logic [ccb_pkg::DIM_W-1:0]           req_bmp_width,
   input  logic [ccb_pkg::DIM_W-1:0]           req_bmp_height,
   input  logic [ccb_pkg::DIM_W-1:0]           req_clip_width,
   input  logic [ccb_pkg::DIM_W-1:0]           req_clip_height,
   input  logic [ccb_pkg::PIX_W-1:0]           req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ccb_pkg::ADDR_W-1:0]          rsp_write_address,
   output logic [ccb_pkg::PIX_W-1:0]           rsp_write_pixel,
   input  logic                                csr_write_enable,
   input  logic [ccb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ccb_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import ccb_pkg::*;

   logic [DIM_W-1:0] screen_width_ff, screen_width_in;
   logic [DIM_W-1:0] screen_height_ff, screen_height_in;
   logic [PIX_W-1:0] transparent_ff, transparent_in;

   logic                 push;
   logic                 pop;
   ccb_job_type          push_job;
   ccb_job_type          head_job;
   ccb_queue_status_type queue_status;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      transparent_in   = transparent_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_write_data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_write_data[DIM_W-1:0];
            CSR_KEY_COLOR:     transparent_in   = csr_write_data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         transparent_ff   <= TRANSPARENT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         transparent_ff   <= transparent_in;
      end
   end

   ccb_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_bmp_width     (req_bmp_width),
      .req_bmp_height    (req_bmp_height),
      .req_clip_width    (req_clip_width),
      .req_clip_height   (req_clip_height),
      .req_pixel         (req_pixel),
      .screen_width      (screen_width_ff),
      .screen_height     (screen_height_ff),
      .key_color         (transparent_ff),
      .queue_status      (queue_status),
      .push              (push),
      .job               (push_job)
   );

   ccb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   ccb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .queue_status      (queue_status),
      .pop               (pop),
      .screen_width      (screen_width_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_pixel   (rsp_write_pixel)
   );

endmodule

### sim/clipped_color_key_blitter_tb.sv
// Self-checking testbench for the color-key sprite blitter: directed table, then random blits.
`timescale 1ns / 1ps

module clipped_color_key_blitter_tb;
   import ccb_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 62;

   typedef struct {
      logic                    func;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [DIM_W-1:0]        bmp_w;
      logic [DIM_W-1:0]        bmp_h;
      logic [DIM_W-1:0]        clip_w;
      logic [DIM_W-1:0]        clip_h;
      logic [PIX_W-1:0]        pixel;
   } blit_item_type;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pix;
   } fb_write_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_WRITE} row_check_type;

   typedef struct {
      row_kind_type          kind;
      blit_item_type         item;
      row_check_type         check;
      logic [ADDR_W-1:0]     lit_addr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_func = FUNC_START;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic [DIM_W-1:0]        req_bmp_width = '0;
   logic [DIM_W-1:0]        req_bmp_height = '0;
   logic [DIM_W-1:0]        req_clip_width = '0;
   logic [DIM_W-1:0]        req_clip_height = '0;
   logic [PIX_W-1:0]        req_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [ADDR_W-1:0]       rsp_write_address;
   logic [PIX_W-1:0]        rsp_write_pixel;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   // blitter state as predicted
   logic [DIM_W-1:0]        scr_w = SCREEN_WIDTH_RESET;
   logic [DIM_W-1:0]        scr_h = SCREEN_HEIGHT_RESET;
   logic [PIX_W-1:0]        key_color = TRANSPARENT_RESET;
   logic signed [POS_W-1:0] sprite_x = '0;
   logic signed [POS_W-1:0] sprite_y = '0;
   logic [DIM_W-1:0]        sprite_w = '0;
   logic [DIM_W-1:0]        sprite_h = '0;
   logic [DIM_W-1:0]        win_w = '0;
   logic [DIM_W-1:0]        win_h = '0;
   logic [DIM_W-1:0]        col_ptr = '0;
   logic [DIM_W-1:0]        row_ptr = '0;

   fb_write_type pending_writes[$];
   dir_row_type  dir_rows[$];

   int fail_count = 0;
   int writes_seen = 0;
   int items_sent = 0;
   int items_done = 0;
   int settings_run = 0;
   int gap_pct = 30;
   bit quiet_tail = 1'b0;
   bit streaming = 1'b0;
   bit long_hold_done = 1'b0;

   clipped_color_key_blitter u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_bmp_width     (req_bmp_width),
      .req_bmp_height    (req_bmp_height),
      .req_clip_width    (req_clip_width),
      .req_clip_height   (req_clip_height),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_pixel   (rsp_write_pixel),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [DIM_W-1:0] cap_dim(input logic [DIM_W-1:0] v);
      return (int'(v) > CCB_MAX_DIM - 1) ? DIM_W'(CCB_MAX_DIM - 1) : v;
   endfunction

   // Advance the predicted walk by one item; return 1 when a write is due.
   function automatic bit blit_step(input blit_item_type it, output fb_write_type wr,
                                    output bit counted);
      int sx;
      int sy;
      int fx;
      int fy;
      bit hit;
      counted = 1'b1;
      wr.addr = '0;
      wr.pix = '0;
      if (it.func == FUNC_START) begin
         sprite_x = it.pos_x;
         sprite_y = it.pos_y;
         sprite_w = cap_dim(it.bmp_w);
         sprite_h = cap_dim(it.bmp_h);
         win_w = cap_dim(it.clip_w);
         win_h = cap_dim(it.clip_h);
         col_ptr = '0;
         row_ptr = '0;
         return 1'b0;
      end
      if (sprite_w == 0 || row_ptr >= sprite_h) begin
         counted = 1'b0;
         return 1'b0;
      end
      sx = int'(sprite_x) + int'(col_ptr);
      sy = int'(sprite_y) + int'(row_ptr);
      fx = (sprite_x < 0) ? 0 : int'(sprite_x);
      fy = (sprite_y < 0) ? 0 : int'(sprite_y);
      hit = sx >= 0 && sy >= 0 && sx < int'(scr_w) && sy < int'(scr_h)
         && (sx - fx) < int'(win_w) && (sy - fy) < int'(win_h)
         && it.pixel != key_color;
      col_ptr = col_ptr + 1'b1;
      if (col_ptr >= sprite_w) begin
         col_ptr = '0;
         row_ptr = row_ptr + 1'b1;
      end
      wr.addr = ADDR_W'(sy * int'(scr_w) + sx);
      wr.pix = it.pixel;
      return hit;
   endfunction

   function automatic blit_item_type start_item(input int x, y, w, h, cw, ch);
      blit_item_type it;
      it.func = FUNC_START;
      it.pos_x = POS_W'(x);
      it.pos_y = POS_W'(y);
      it.bmp_w = DIM_W'(w);
      it.bmp_h = DIM_W'(h);
      it.clip_w = DIM_W'(cw);
      it.clip_h = DIM_W'(ch);
      it.pixel = PIX_W'($urandom);
      return it;
   endfunction

   function automatic blit_item_type pixel_item(input int p);
      blit_item_type it;
      it.func = FUNC_PIXEL;
      it.pos_x = POS_W'($urandom);
      it.pos_y = POS_W'($urandom);
      it.bmp_w = DIM_W'($urandom);
      it.bmp_h = DIM_W'($urandom);
      it.clip_w = DIM_W'($urandom);
      it.clip_h = DIM_W'($urandom);
      it.pixel = PIX_W'(p);
      return it;
   endfunction

   function automatic dir_row_type item_row(input blit_item_type it,
                                            input row_check_type chk, input int addr);
      dir_row_type r;
      r.kind = ROW_ITEM;
      r.item = it;
      r.check = chk;
      r.lit_addr = ADDR_W'(addr);
      r.csr_idx = '0;
      r.csr_data = '0;
      return r;
   endfunction

   function automatic dir_row_type csr_row(input logic [CSR_IDX_W-1:0] idx, input int data);
      dir_row_type r;
      r = item_row(pixel_item(0), CHK_SILENT, 0);
      r.kind = ROW_CSR;
      r.csr_idx = idx;
      r.csr_data = CSR_DATA_W'(data);
      return r;
   endfunction

   task automatic take_gap();
      if (!quiet_tail && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drive_item(input blit_item_type it);
      req_valid <= 1'b1;
      req_func <= it.func;
      req_pos_x <= it.pos_x;
      req_pos_y <= it.pos_y;
      req_bmp_width <= it.bmp_w;
      req_bmp_height <= it.bmp_h;
      req_clip_width <= it.clip_w;
      req_clip_height <= it.clip_h;
      req_pixel <= it.pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic offer_item(input blit_item_type it);
      fb_write_type wr;
      bit counted;
      take_gap();
      drive_item(it);
      if (blit_step(it, wr, counted)) pending_writes.push_back(wr);
      if (counted) items_done++;
   endtask

   // Hold the request side until every predicted write is out and the pipe is empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SCREEN_WIDTH: scr_w = data;
         CSR_SCREEN_HEIGHT: scr_h = data;
         CSR_KEY_COLOR: key_color = data[PIX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic random_blits(input int budget);
      int goal;
      int bw;
      int bh;
      int cw;
      int ch;
      int x;
      int y;
      int mx;
      int my;
      int npix;
      goal = items_done + budget;
      streaming = 1'b1;
      while (items_done < goal) begin
         case ($urandom_range(0, 9))
            0: begin
               bw = $urandom_range(512, 1023);
               bh = $urandom_range(0, 1);
            end
            1: begin
               bw = $urandom_range(1, 3);
               bh = $urandom_range(512, 1023);
            end
            2: begin
               bw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
               bh = (bw == 0) ? $urandom_range(0, 4) : 0;
            end
            default: begin
               bw = $urandom_range(1, 8);
               bh = $urandom_range(1, 6);
            end
         endcase
         if ($urandom_range(0, 1)) begin
            cw = $urandom_range(0, 1023);
            ch = $urandom_range(0, 1023);
         end else begin
            cw = $urandom_range(0, bw);
            ch = $urandom_range(0, bh);
         end
         if ($urandom_range(0, 3) == 0) begin
            x = int'($urandom_range(0, 2047)) - 1024;
            y = int'($urandom_range(0, 2047)) - 1024;
         end else begin
            mx = ((bw > 1000) ? 1000 : bw) + 2;
            my = ((bh > 1000) ? 1000 : bh) + 2;
            x = int'($urandom_range(0, int'(scr_w) + mx + 1)) - mx;
            y = int'($urandom_range(0, int'(scr_h) + my + 1)) - my;
            if (x > 1023) x = 1023;
            if (y > 1023) y = 1023;
         end
         offer_item(start_item(x, y, bw, bh, cw, ch));
         npix = bw * bh;
         if (npix > 40) begin
            npix = $urandom_range(0, 12);
         end else begin
            case ($urandom_range(0, 9))
               0: npix = npix + $urandom_range(1, 3);
               1: npix = $urandom_range(0, npix);
               default: ;
            endcase
         end
         repeat (npix) begin
            offer_item(pixel_item(($urandom_range(0, 4) == 0) ? int'(key_color)
                                                              : int'($urandom_range(0, 255))));
         end
      end
      streaming = 1'b0;
   endtask

   always @(posedge clock) begin : write_check
      fb_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         writes_seen++;
         if (pending_writes.size() == 0) begin
            $error("unexpected write: write_address %0d write_pixel %0d",
                   rsp_write_address, rsp_write_pixel);
            fail_count++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_write_address !== want.addr) begin
               $error("write_address: expected %0d, got %0d", want.addr, rsp_write_address);
               fail_count++;
            end
            if (rsp_write_pixel !== want.pix) begin
               $error("write_pixel: expected %0d, got %0d", want.pix, rsp_write_pixel);
               fail_count++;
            end
         end
      end
   end

   initial begin : receiver
      while (reset) @(posedge clock);
      forever begin
         if (!quiet_tail && !long_hold_done && streaming && writes_seen >= 20) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      fb_write_type wr;
      fb_write_type lit;
      bit counted;
      bit hit;
      int sw;
      int sh;
      int tc;

      dir_rows.push_back(item_row(start_item(0, 0, 2, 2, 1023, 1023), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(5), CHK_WRITE, 0));
      dir_rows.push_back(item_row(pixel_item(0), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(255), CHK_WRITE, 220));
      dir_rows.push_back(item_row(pixel_item(7), CHK_WRITE, 221));
      dir_rows.push_back(item_row(pixel_item(9), CHK_SILENT, 0));
      dir_rows.push_back(item_row(start_item(-1024, -1024, 1023, 1023, 0, 0), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(1), CHK_SILENT, 0));
      dir_rows.push_back(item_row(start_item(1023, 1023, 1, 1, 1023, 1023), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(3), CHK_SILENT, 0));
      // negative x: the two left columns drop, no wrap into the row above
      dir_rows.push_back(item_row(start_item(-2, 3, 3, 1, 1023, 1023), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(11), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(12), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(13), CHK_WRITE, 660));
      dir_rows.push_back(item_row(start_item(219, 175, 2, 1, 1, 1), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(17), CHK_WRITE, 38719));
      dir_rows.push_back(item_row(pixel_item(18), CHK_SILENT, 0));
      dir_rows.push_back(item_row(start_item(10, 10, 3, 1, 2, 1), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(30), CHK_MODEL, 0));
      dir_rows.push_back(item_row(pixel_item(31), CHK_MODEL, 0));
      dir_rows.push_back(item_row(pixel_item(32), CHK_MODEL, 0));
      dir_rows.push_back(item_row(start_item(5, 5, 0, 4, 1023, 1023), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(20), CHK_SILENT, 0));
      dir_rows.push_back(csr_row(CSR_SCREEN_WIDTH, 0));
      dir_rows.push_back(csr_row(CSR_KEY_COLOR, 255));
      dir_rows.push_back(item_row(start_item(0, 0, 1, 1, 1023, 1023), CHK_SILENT, 0));
      dir_rows.push_back(item_row(pixel_item(21), CHK_SILENT, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            wait_drained();
            csr_put(dir_rows[i].csr_idx, dir_rows[i].csr_data);
         end else begin
            take_gap();
            drive_item(dir_rows[i].item);
            hit = blit_step(dir_rows[i].item, wr, counted);
            case (dir_rows[i].check)
               CHK_WRITE: begin
                  lit.addr = dir_rows[i].lit_addr;
                  lit.pix = dir_rows[i].item.pixel;
                  pending_writes.push_back(lit);
               end
               CHK_MODEL: if (hit) pending_writes.push_back(wr);
               default: ;
            endcase
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            1: begin
               sw = 1;
               sh = 1;
               tc = 0;
            end
            3: begin
               sw = 1023;
               sh = 1023;
               tc = 255;
            end
            default: begin
               sw = $urandom_range(8, 40);
               sh = $urandom_range(8, 40);
               tc = $urandom_range(0, 255);
            end
         endcase
         csr_put(CSR_SCREEN_WIDTH, CSR_DATA_W'(sw));
         csr_put(CSR_SCREEN_HEIGHT, CSR_DATA_W'(sh));
         csr_put(CSR_KEY_COLOR, CSR_DATA_W'(tc));
         settings_run++;
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 15;
            default: gap_pct = 40;
         endcase
         if (p == PHASES - 1) quiet_tail = 1'b1;
         random_blits(PHASE_ITEMS);
      end

      wait_drained();
      $display("blitter run: %0d items transferred, %0d frame buffer writes checked",
               items_sent, writes_seen);
      $display("screen settings after the directed table: %0d, long output hold taken: %0d",
               settings_run, long_hold_done);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
